/* rtl/core/scmm_pkg.sv */
package scmm_pkg;

	localparam int ACC_W = 40;
	localparam int VAL_W = 16;
	localparam int ROW_W = 6;
	localparam int SLOT_W = 11;

	localparam logic [1:0] KIND_COL_START = 2'd0;
	localparam logic [1:0] KIND_A_ENTRY   = 2'd1;
	localparam logic [1:0] KIND_B_ENTRY   = 2'd2;

	localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
	localparam logic [1:0] REG_INNER_COUNT = 2'd1;
	localparam logic [1:0] REG_THRESHOLD   = 2'd2;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// saturating add of a Q4.30 product term to a Q10.30 accumulator
	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [33:0] b
	);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {{(ACC_W-33){b[33]}}, b};
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		return s[ACC_W-1:0];
	endfunction

endpackage

/* rtl/core/scmm_mag.sv */
// Squared magnitude with saturation to 64 bits, two register stages.
module scmm_mag (
	input  logic                          clk,
	input  logic signed [scmm_pkg::ACC_W-1:0] re,
	input  logic signed [scmm_pkg::ACC_W-1:0] im,
	output logic [63:0]                   mag
);
	import scmm_pkg::*;

	logic [ACC_W-1:0] abs_re, abs_im;
	logic [31:0] m_re_s1, m_im_s1;
	logic big_s1;
	logic [63:0] sq_re_s2, sq_im_s2;
	logic big_s2;
	logic [64:0] sum;

	assign abs_re = re[ACC_W-1] ? ACC_W'(-re) : ACC_W'(re);
	assign abs_im = im[ACC_W-1] ? ACC_W'(-im) : ACC_W'(im);

	always_ff @(posedge clk) begin
		m_re_s1 <= abs_re[31:0];
		m_im_s1 <= abs_im[31:0];
		big_s1  <= (abs_re[ACC_W-1:32] != '0) || (abs_im[ACC_W-1:32] != '0);
		sq_re_s2 <= 64'(m_re_s1) * 64'(m_re_s1);
		sq_im_s2 <= 64'(m_im_s1) * 64'(m_im_s1);
		big_s2   <= big_s1;
	end

	assign sum = {1'b0, sq_re_s2} + {1'b0, sq_im_s2};
	assign mag = (big_s2 || sum[64]) ? '1 : sum[63:0];

endmodule

/* rtl/core/sparse_complex_column_matmul.sv */
// Sparse complex column multiply (Gustavson, compressed-column A).
// Input channel in_valid/in_ready carries one beat per item. kind 0 writes
// a column start pointer, kind 1 an A nonzero, kind 2 a B column entry.
// Loads and ignored items keep the block idle, so they stream back to back.
// A B entry reads its two column pointers (ST_PTR0, ST_PTR1), then walks
// the A column one nonzero at a time: A read in ST_WALK, accumulator read
// in ST_ARD, add and write back in ST_ACC (skipped for a row outside
// row_count). The walk ends in ST_WALK and the next beat waits for ST_IDLE.
// On column_end rows 0..MAX_ROWS-1 are scanned in order: an untouched row
// is passed over in ST_SRD, a touched row runs to ST_SDEC (accumulator read
// plus the two-stage magnitude). Kept rows leave on out_valid/out_ready from
// one output register; the latest kept row is held back so it can carry
// last_of_column. An empty column gives one marker beat. Scanned rows clear.
// A stalled receiver holds the output register and the scan; the input
// stays blocked until the last beat of the column has been taken.
// Reset clears the touched flags (untouched accumulators read as zero),
// the registers and control state; pointer and A stores hold garbage.
// Configuration is written via cfg_we/cfg_index/cfg_data while idle.
module sparse_complex_column_matmul #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_INNER = 64,
	parameter int MAX_A_NNZ = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [62:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [10:0] slot,
	input  logic [10:0] pointer_value,
	input  logic [5:0]  row,
	input  logic signed [15:0] value_re,
	input  logic signed [15:0] value_im,
	input  logic        column_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  result_row,
	output logic signed [39:0] result_re,
	output logic signed [39:0] result_im,
	output logic        has_entry,
	output logic        last_of_column,
	output logic [6:0]  column_entries
);
	import scmm_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int IW = $clog2(MAX_INNER + 1);
	localparam int NW = $clog2(MAX_A_NNZ);
	localparam int PW = $clog2(MAX_A_NNZ + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PTR0, ST_PTR1, ST_WALK, ST_ARD, ST_ACC,
		ST_SRD, ST_SMAG0, ST_SMAG1, ST_SMAG2, ST_SDEC, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;
	logic [6:0] row_count_q, inner_count_q;
	logic [62:0] thr_q;

	// memories
	logic [10:0] col_mem [MAX_INNER+1];
	logic [5:0]  arow_mem [MAX_A_NNZ];
	logic [15:0] are_mem [MAX_A_NNZ];
	logic [15:0] aim_mem [MAX_A_NNZ];
	logic [ACC_W-1:0] accre_mem [MAX_ROWS];
	logic [ACC_W-1:0] accim_mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] touched_q;

	logic [10:0] col_rd_q;
	logic [IW-1:0] col_addr;
	logic [PW-1:0] k_q, end_q;
	logic [5:0] br_row_q;
	logic signed [15:0] br_q, bi_q;
	logic cend_q;
	logic [5:0] ar_row_s1;
	logic signed [15:0] ar_re_s1, ar_im_s1;

	logic signed [31:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic [ACC_W-1:0] acc_re_rd_q, acc_im_rd_q;
	logic tch_rd_q;
	logic [RW-1:0] acc_raddr;
	logic signed [33:0] t_re, t_im;
	logic [ACC_W-1:0] cur_re, cur_im, new_re, new_im;

	logic [RW-1:0] scan_q;
	logic [6:0] kept_q;
	logic [63:0] mag, mag_q;
	logic pend_valid_q;
	logic [5:0] pend_row_q;
	logic [ACC_W-1:0] pend_re_q, pend_im_q;

	logic in_fire, b_ok, a_rd, row_ok_s1, last_row, keep;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= 7'd64;
			inner_count_q <= 7'd64;
			thr_q         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT:   row_count_q <= cfg_data[6:0];
				REG_INNER_COUNT: inner_count_q <= cfg_data[6:0];
				REG_THRESHOLD:   thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// loads
	always_ff @(posedge clk) begin
		if (in_fire && kind == KIND_COL_START && 32'(slot) <= MAX_INNER)
			col_mem[IW'(slot)] <= pointer_value;
		if (in_fire && kind == KIND_A_ENTRY && 32'(slot) < MAX_A_NNZ) begin
			arow_mem[NW'(slot)] <= row;
			are_mem[NW'(slot)]  <= value_re;
			aim_mem[NW'(slot)]  <= value_im;
		end
	end

	assign b_ok = (7'(row) < inner_count_q) && (32'(row) < MAX_INNER);

	// start pointer is read on accept, end pointer in ST_PTR0
	always_comb begin
		col_addr = IW'(row);
		if (state_q == ST_PTR0) col_addr = IW'(br_row_q) + IW'(1);
	end
	always_ff @(posedge clk) col_rd_q <= col_mem[col_addr];

	// A read, one nonzero per walk step
	assign a_rd = (state_q == ST_WALK) && (k_q < end_q);
	always_ff @(posedge clk) begin
		if (a_rd) begin
			ar_row_s1 <= arow_mem[NW'(k_q)];
			ar_re_s1  <= are_mem[NW'(k_q)];
			ar_im_s1  <= aim_mem[NW'(k_q)];
		end
	end

	assign row_ok_s1 = (7'(ar_row_s1) < row_count_q) && (32'(ar_row_s1) < MAX_ROWS);
	assign acc_raddr = (state_q == ST_ARD) ? RW'(ar_row_s1) : scan_q;

	always_ff @(posedge clk) begin
		p_rr_s2 <= ar_re_s1 * br_q;
		p_ii_s2 <= ar_im_s1 * bi_q;
		p_ri_s2 <= ar_re_s1 * bi_q;
		p_ir_s2 <= ar_im_s1 * br_q;
	end

	assign t_re = 34'(p_rr_s2) - 34'(p_ii_s2);
	assign t_im = 34'(p_ri_s2) + 34'(p_ir_s2);
	// untouched rows read as zero
	assign cur_re = tch_rd_q ? acc_re_rd_q : '0;
	assign cur_im = tch_rd_q ? acc_im_rd_q : '0;
	assign new_re = sat_add(cur_re, t_re);
	assign new_im = sat_add(cur_im, t_im);

	// one nonzero in flight at a time, so read and write back never overlap
	always_ff @(posedge clk) begin
		acc_re_rd_q <= accre_mem[acc_raddr];
		acc_im_rd_q <= accim_mem[acc_raddr];
		tch_rd_q    <= touched_q[acc_raddr];
		if (state_q == ST_ACC) begin
			accre_mem[RW'(ar_row_s1)] <= new_re;
			accim_mem[RW'(ar_row_s1)] <= new_im;
		end
	end

	scmm_mag u_mag (.clk(clk), .re(cur_re), .im(cur_im), .mag(mag));
	always_ff @(posedge clk) mag_q <= mag;

	assign last_row = (32'(scan_q) == MAX_ROWS - 1);
	assign keep = tch_rd_q && (mag_q > {1'b0, thr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			touched_q <= '0;
			out_valid <= 1'b0;
			k_q <= '0; end_q <= '0; scan_q <= '0; kept_q <= '0;
			cend_q <= 1'b0; br_row_q <= '0; br_q <= '0; bi_q <= '0;
			pend_valid_q <= 1'b0; pend_row_q <= '0; pend_re_q <= '0; pend_im_q <= '0;
			result_row <= '0; result_re <= '0; result_im <= '0;
			has_entry <= 1'b0; last_of_column <= 1'b0; column_entries <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_fire && kind == KIND_B_ENTRY) begin
					br_row_q <= row; br_q <= value_re; bi_q <= value_im;
					cend_q <= column_end;
					scan_q <= '0; kept_q <= '0;
					if (b_ok) state_q <= ST_PTR0;
					else if (column_end) state_q <= ST_SRD;
				end
				ST_PTR0: begin
					k_q <= PW'(col_rd_q);
					state_q <= ST_PTR1;
				end
				ST_PTR1: begin
					end_q <= (32'(col_rd_q) > MAX_A_NNZ) ? PW'(MAX_A_NNZ) : PW'(col_rd_q);
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (a_rd) begin
						k_q <= k_q + PW'(1);
						state_q <= ST_ARD;
					end else
						state_q <= cend_q ? ST_SRD : ST_IDLE;
				end
				ST_ARD: state_q <= row_ok_s1 ? ST_ACC : ST_WALK;
				ST_ACC: begin
					touched_q[RW'(ar_row_s1)] <= 1'b1;
					state_q <= ST_WALK;
				end
				ST_SRD: begin
					if (touched_q[scan_q]) state_q <= ST_SMAG0;
					else if (last_row) state_q <= ST_FIN;
					else scan_q <= scan_q + RW'(1);
				end
				ST_SMAG0: state_q <= ST_SMAG1;
				ST_SMAG1: state_q <= ST_SMAG2;
				ST_SMAG2: state_q <= ST_SDEC;
				ST_SDEC: if (!out_valid) begin
					if (keep) begin
						if (pend_valid_q) begin
							out_valid <= 1'b1;
							result_row <= pend_row_q;
							result_re <= pend_re_q;
							result_im <= pend_im_q;
							has_entry <= 1'b1;
							last_of_column <= 1'b0;
							column_entries <= '0;
						end
						pend_valid_q <= 1'b1;
						pend_row_q <= 6'(scan_q);
						pend_re_q <= cur_re;
						pend_im_q <= cur_im;
						kept_q <= kept_q + 7'd1;
					end
					touched_q[scan_q] <= 1'b0;
					if (last_row) state_q <= ST_FIN;
					else begin
						scan_q <= scan_q + RW'(1);
						state_q <= ST_SRD;
					end
				end
				// held row closes the column, or the empty-column marker
				ST_FIN: if (!out_valid) begin
					out_valid <= 1'b1;
					result_row <= pend_valid_q ? pend_row_q : '0;
					result_re <= pend_valid_q ? pend_re_q : '0;
					result_im <= pend_valid_q ? pend_im_q : '0;
					has_entry <= pend_valid_q;
					last_of_column <= 1'b1;
					column_entries <= kept_q;
					pend_valid_q <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_OUT: if (!out_valid) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/scmm_checker.sv */
module scmm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic has_entry,
	input logic last_of_column,
	input logic [6:0] column_entries
);
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid) else $error("in beat withdrawn");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out beat dropped");
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_entry |-> last_of_column) else $error("marker not last");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_column |-> column_entries == 7'd0) else $error("count early");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during emission");
endmodule

bind sparse_complex_column_matmul scmm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .has_entry(has_entry),
	.last_of_column(last_of_column), .column_entries(column_entries)
);

/* verif/tb.sv */
module tb;
	import scmm_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] REG_NONE    = 2'd3;
	localparam int DRAIN_CYCLES = 1200;
	localparam int STALL_LIMIT  = 20000;
	localparam logic [62:0] THR_MAX = {63{1'b1}};

	typedef struct {
		logic [5:0]  row;
		logic signed [39:0] re;
		logic signed [39:0] im;
		logic        has;
		logic        last;
		logic [6:0]  cnt;
	} col_entry_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [62:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [10:0] slot = '0;
	logic [10:0] pointer_value = '0;
	logic [5:0] row = '0;
	logic signed [15:0] value_re = '0;
	logic signed [15:0] value_im = '0;
	logic column_end = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [5:0] result_row;
	logic signed [39:0] result_re;
	logic signed [39:0] result_im;
	logic has_entry;
	logic last_of_column;
	logic [6:0] column_entries;

	sparse_complex_column_matmul uut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [6:0]  rows_cfg = 7'd64;
	logic [6:0]  inner_cfg = 7'd64;
	logic [62:0] thr_cfg = '0;
	logic [10:0] ptr_mem [0:64];
	logic [5:0]  arow_mem [0:1023];
	logic signed [15:0] are_mem [0:1023];
	logic signed [15:0] aim_mem [0:1023];
	bit ptr_wr [0:64];
	bit a_wr [0:1023];
	logic signed [39:0] sum_re [0:63];
	logic signed [39:0] sum_im [0:63];
	logic [63:0] touched = '0;

	col_entry_t expected_rows[$];
	bit quiet = 0;
	int n_errors = 0, n_items = 0, n_results = 0, n_columns = 0, n_dropped = 0;
	int idle_cycles = 0, stall_left = 0;

	initial begin
		for (int i = 0; i < 64; i++) begin
			sum_re[i] = '0;
			sum_im[i] = '0;
		end
	end

	function automatic void queue_beat(col_entry_t e);
		expected_rows = {expected_rows, e};
	endfunction

	function automatic logic signed [39:0] acc_sat(longint s);
		if (s > 64'sd549755813887) return ACC_MAX;
		if (s < -64'sd549755813888) return ACC_MIN;
		return s[39:0];
	endfunction

	function automatic logic [63:0] square_sat(logic signed [39:0] v);
		longint x;
		x = v;
		if (x < 0) x = -x;
		if (x >= 64'sd4294967296) return '1;
		return x * x;
	endfunction

	function automatic logic [63:0] power_of(logic signed [39:0] re, logic signed [39:0] im);
		logic [64:0] s;
		s = {1'b0, square_sat(re)} + {1'b0, square_sat(im)};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic int eff(logic [6:0] v);
		return (v > 64) ? 64 : v;
	endfunction

	// a B row whose walk only reads loaded pointers and nonzeros
	function automatic bit column_loaded(int p);
		int s, e;
		if (p >= eff(inner_cfg)) return 1;
		if (!ptr_wr[p] || !ptr_wr[p+1]) return 0;
		s = ptr_mem[p];
		e = ptr_mem[p+1];
		if (e > 1024) e = 1024;
		for (int k = s; k < e; k++)
			if (!a_wr[k]) return 0;
		return 1;
	endfunction

	function automatic void accumulate_item(logic [1:0] k, logic [10:0] s, logic [10:0] p,
		logic [5:0] r, logic signed [15:0] vr, logic signed [15:0] vi, logic ce);
		col_entry_t kept [0:63];
		int n, st, en;
		longint br, bi, ar, ai;
		n = 0;
		br = vr;
		bi = vi;
		if (k == KIND_COL_START) begin
			if (s <= 64) begin
				ptr_mem[s] = p;
				ptr_wr[s] = 1;
			end
			return;
		end
		if (k == KIND_A_ENTRY) begin
			if (s < 1024) begin
				arow_mem[s] = r;
				are_mem[s] = vr;
				aim_mem[s] = vi;
				a_wr[s] = 1;
			end
			return;
		end
		if (k != KIND_B_ENTRY) return;
		if (r < eff(inner_cfg)) begin
			st = ptr_mem[r];
			en = ptr_mem[r+1];
			if (en > 1024) en = 1024;
			for (int j = st; j < en; j++) begin
				if (arow_mem[j] >= eff(rows_cfg)) continue;
				ar = are_mem[j];
				ai = aim_mem[j];
				sum_re[arow_mem[j]] = acc_sat(longint'(sum_re[arow_mem[j]]) + ar*br - ai*bi);
				sum_im[arow_mem[j]] = acc_sat(longint'(sum_im[arow_mem[j]]) + ar*bi + ai*br);
				touched[arow_mem[j]] = 1'b1;
			end
		end
		if (!ce) return;
		n_columns++;
		for (int i = 0; i < 64; i++) begin
			if (touched[i]) begin
				if (power_of(sum_re[i], sum_im[i]) > {1'b0, thr_cfg}) begin
					kept[n] = '{i[5:0], sum_re[i], sum_im[i], 1'b1, 1'b0, 7'd0};
					n++;
				end else
					n_dropped++;
			end
			sum_re[i] = '0;
			sum_im[i] = '0;
		end
		touched = '0;
		if (n == 0) begin
			queue_beat('{6'd0, 40'sd0, 40'sd0, 1'b0, 1'b1, 7'd0});
			return;
		end
		kept[n-1].last = 1'b1;
		kept[n-1].cnt = n[6:0];
		for (int i = 0; i < n; i++) queue_beat(kept[i]);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		n_errors++;
	endtask

	// result checker
	col_entry_t exp_e;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_rows.size() == 0)
				report("unexpected result beat, row", result_row, 0);
			else begin
				exp_e = expected_rows.pop_front();
				if (has_entry !== exp_e.has) report("has_entry", has_entry, exp_e.has);
				if (result_row !== exp_e.row) report("result_row", result_row, exp_e.row);
				if (result_re !== exp_e.re) report("result_re", result_re, exp_e.re);
				if (result_im !== exp_e.im) report("result_im", result_im, exp_e.im);
				if (last_of_column !== exp_e.last)
					report("last_of_column", last_of_column, exp_e.last);
				if (column_entries !== exp_e.cnt)
					report("column_entries", column_entries, exp_e.cnt);
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 11);
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else
			out_ready <= 1'b1;
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout, %0d results still expected", expected_rows.size());
			$display("tb NOT OK");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	function automatic logic [15:0] rand_q15();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send(logic [1:0] k, logic [10:0] s, logic [10:0] p, logic [5:0] r,
		logic [15:0] vr, logic [15:0] vi, logic ce);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		slot <= s;
		pointer_value <= p;
		row <= r;
		value_re <= vr;
		value_im <= vi;
		column_end <= ce;
		do @(posedge clk); while (!in_ready);
		n_items++;
		accumulate_item(k, s, p, r, vr, vi, ce);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [62:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROW_COUNT:   rows_cfg = v[6:0];
			REG_INNER_COUNT: inner_cfg = v[6:0];
			REG_THRESHOLD:   thr_cfg = v;
			default: ;
		endcase
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send(KIND_UNUSED, 11'($urandom), 11'($urandom), 6'($urandom),
				rand_q15(), rand_q15(), 1'($urandom));
			1: send(KIND_COL_START, 11'($urandom_range(65, 2047)), 11'($urandom), 6'($urandom),
				rand_q15(), rand_q15(), 1'($urandom));
			2: send(KIND_A_ENTRY, 11'($urandom_range(1024, 2047)), 11'($urandom),
				6'($urandom), rand_q15(), rand_q15(), 1'($urandom));
			default: send(KIND_A_ENTRY, 11'($urandom_range(0, 1023)), 11'($urandom),
				6'($urandom), rand_q15(), rand_q15(), 1'b1);
		endcase
	endtask

	task automatic load_random_matrix(int max_per_col);
		int total;
		total = 0;
		for (int c = 0; c <= 64; c++) begin
			send(KIND_COL_START, c[10:0], total[10:0], 6'($urandom), rand_q15(), rand_q15(), 1'b0);
			if (c < 64) total += $urandom_range(0, max_per_col);
		end
		for (int j = 0; j < total; j++)
			send(KIND_A_ENTRY, j[10:0], 11'($urandom), 6'($urandom), rand_q15(), rand_q15(), 1'b0);
	endtask

	task automatic random_column();
		int nb, r;
		nb = $urandom_range(1, 5);
		for (int j = 0; j < nb; j++) begin
			if ($urandom_range(0, 9) == 0) send_noise();
			r = $urandom_range(0, 63);
			for (int t = 0; t < 20 && !column_loaded(r); t++) r = $urandom_range(0, 63);
			if (!column_loaded(r)) r = 0;
			send(KIND_B_ENTRY, 11'($urandom), 11'($urandom), r[5:0], rand_q15(), rand_q15(),
				j == nb - 1);
		end
	endtask

	task automatic test_directed();
		// col 2 empty, col 3 has start above end, col 5 a long column for saturation,
		// col 63 ends past the store
		send(KIND_COL_START, 11'd0, 11'd0, 6'd0, 16'h0, 16'h0, 1'b0);
		send(KIND_COL_START, 11'd1, 11'd2, 6'd0, 16'h0, 16'h0, 1'b0);
		send(KIND_COL_START, 11'd2, 11'd3, 6'd0, 16'h0, 16'h0, 1'b0);
		send(KIND_COL_START, 11'd3, 11'd3, 6'd0, 16'h0, 16'h0, 1'b1);
		send(KIND_COL_START, 11'd4, 11'd1, 6'd0, 16'h0, 16'h0, 1'b0);
		send(KIND_COL_START, 11'd5, 11'd40, 6'd0, 16'h0, 16'h0, 1'b0);
		send(KIND_COL_START, 11'd6, 11'd72, 6'd0, 16'h0, 16'h0, 1'b0);
		send(KIND_COL_START, 11'd63, 11'd1020, 6'd0, 16'h0, 16'h0, 1'b0);
		send(KIND_COL_START, 11'd64, 11'd2000, 6'd0, 16'h0, 16'h0, 1'b0);
		send(KIND_COL_START, 11'd2047, 11'd2047, 6'd63, 16'hffff, 16'hffff, 1'b1);
		send(KIND_A_ENTRY, 11'd0, 11'd0, 6'd0, 16'h7fff, 16'h8000, 1'b0);
		send(KIND_A_ENTRY, 11'd1, 11'd0, 6'd63, 16'h8000, 16'h8000, 1'b0);
		send(KIND_A_ENTRY, 11'd2, 11'd0, 6'd10, 16'h0001, 16'h0000, 1'b1);
		for (int j = 1020; j < 1024; j++)
			send(KIND_A_ENTRY, j[10:0], 11'd0, 6'd7, rand_q15(), rand_q15(), 1'b0);
		for (int j = 40; j < 72; j++)
			send(KIND_A_ENTRY, j[10:0], 11'd0, 6'd9, 16'h8000, 16'h8000, 1'b0);
		send(KIND_A_ENTRY, 11'd2047, 11'h7ff, 6'd1, 16'h1234, 16'h4321, 1'b1);
		send(KIND_UNUSED, 11'd5, 11'd5, 6'd5, 16'h7fff, 16'h7fff, 1'b1);
		send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd0, 16'h8000, 16'h7fff, 1'b0);
		send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd1, 16'h7fff, 16'h8000, 1'b0);
		send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd63, 16'h8000, 16'h8000, 1'b1);
		send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd2, 16'h7fff, 16'h7fff, 1'b1);
		send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd3, 16'h7fff, 16'h7fff, 1'b1);
		// drive row 9 into the positive and then the negative rail
		for (int j = 0; j < 9; j++)
			send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd5, 16'h8000, 16'h7fff, j == 8);
		for (int j = 0; j < 9; j++)
			send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd5, 16'h7fff, 16'h8000, j == 8);
	endtask

	task automatic test_registers();
		logic [62:0] thr [0:4];
		logic [6:0] rc [0:4];
		logic [6:0] ic [0:4];
		rc = '{7'd1, 7'd64, 7'd8, 7'd100, 7'd33};
		ic = '{7'd1, 7'd64, 7'd6, 7'd127, 7'd64};
		thr = '{63'd0, THR_MAX, 63'h100_0000_0000, 63'($urandom), 63'd0};
		write_reg(REG_NONE, 63'h55);
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_ROW_COUNT, {56'd0, rc[ph]});
			write_reg(REG_INNER_COUNT, {56'd0, ic[ph]});
			write_reg(REG_THRESHOLD, thr[ph]);
			// column that saturates row 9 where the counts admit it, then one column of B rows 0, 1 and 63
			for (int j = 0; j < 9; j++)
				send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd5, 16'h8000, 16'h7fff, j == 8);
			send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd0, rand_q15(), rand_q15(), 1'b0);
			send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd1, rand_q15(), rand_q15(), 1'b0);
			send(KIND_B_ENTRY, 11'd0, 11'd0, 6'd63, rand_q15(), rand_q15(), 1'b1);
		end
		write_reg(REG_ROW_COUNT, 63'd64);
		write_reg(REG_INNER_COUNT, 63'd64);
		write_reg(REG_THRESHOLD, 63'd0);
	endtask

	task automatic test_random();
		int start;
		start = n_items;
		load_random_matrix(2);
		while (n_items - start < 150) begin
			if (n_items - start > 110) quiet = 1;
			random_column();
		end
		quiet = 1;
		write_reg(REG_THRESHOLD, 63'h40_0000_0000_0000);
		for (int j = 0; j < 12; j++) random_column();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_random();
		settle();
		$display("%0d items in, %0d result beats over %0d columns", n_items, n_results, n_columns);
		$display("%0d touched rows fell under the threshold; %0d mismatches", n_dropped, n_errors);
		if (n_errors == 0 && expected_rows.size() == 0)
			$display("tb OK");
		else begin
			if (expected_rows.size() != 0)
				report("results never arrived", 0, expected_rows.size());
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
